/* sv/dmacc_pkg.sv */
// Shared types, codes and load rules of the four-channel DMA engine.
package dmacc_pkg;

  localparam int MAX_CH = 4;
  localparam int ADDR_W = 28;
  localparam int CNT_W  = 17;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam logic [1:0] REG_SRC = 2'd0;
  localparam logic [1:0] REG_DST = 2'd1;
  localparam logic [1:0] REG_CNT = 2'd2;
  localparam logic [1:0] REG_CTL = 2'd3;

  localparam logic [1:0] STEP_INC    = 2'd0;
  localparam logic [1:0] STEP_DEC    = 2'd1;
  localparam logic [1:0] STEP_FIXED  = 2'd2;
  localparam logic [1:0] STEP_RELOAD = 2'd3;

  localparam logic [1:0] TIMING_IMMEDIATE = 2'd0;
  localparam logic [1:0] WIDE_CH          = 2'd3;
  localparam logic [1:0] NARROW_SRC_CH    = 2'd0;

  localparam int CTL_DSTEP_LO = 5;
  localparam int CTL_SSTEP_LO = 7;
  localparam int CTL_REPEAT   = 9;
  localparam int CTL_WIDE     = 10;
  localparam int CTL_TIMING_LO = 12;
  localparam int CTL_IRQ      = 14;
  localparam int CTL_ENABLE   = 15;

  typedef struct packed {
    logic [15:0]       ctl;
    logic [31:0]       dst_reg;
    logic [15:0]       cnt_reg;
    logic [ADDR_W-1:0] cur_src;
    logic [ADDR_W-1:0] cur_dst;
    logic [CNT_W-1:0]  rem;
  } chan_t;

  typedef struct packed {
    logic [15:0]       ctl;
    logic [ADDR_W-1:0] cur_src;
    logic [ADDR_W-1:0] cur_dst;
    logic [CNT_W-1:0]  rem;
  } chan_upd_t;

  typedef struct packed {
    logic [1:0]        channel;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] write_addr;
    logic              wide;
    logic              finished;
    logic              irq;
  } beat_t;

  function automatic logic [ADDR_W-1:0] load_src(logic [1:0] ch, logic [31:0] sreg);
    return (ch == NARROW_SRC_CH) ? {1'b0, sreg[ADDR_W-2:0]} : sreg[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] load_dst(logic [1:0] ch, logic [31:0] dreg);
    return (ch == WIDE_CH) ? dreg[ADDR_W-1:0] : {1'b0, dreg[ADDR_W-2:0]};
  endfunction

  function automatic logic [CNT_W-1:0] load_count(logic [1:0] ch, logic [15:0] creg);
    logic [CNT_W-1:0] c;
    if (ch == WIDE_CH) begin
      c = (creg == 16'd0) ? 17'h10000 : {1'b0, creg};
    end else begin
      c = (creg[13:0] == 14'd0) ? 17'h04000 : {3'd0, creg[13:0]};
    end
    return c;
  endfunction

endpackage

/* sv/dmacc_step.sv */
// One transfer beat of the served channel: aligned addresses, address moves, count and end rules.
module dmacc_step (
  input  dmacc_pkg::chan_t     st,
  input  logic [1:0]           ch,
  output dmacc_pkg::beat_t     beat,
  output dmacc_pkg::chan_upd_t upd
);

  logic [1:0]                   dstep;
  logic [1:0]                   sstep;
  logic                         wide;
  logic [dmacc_pkg::ADDR_W-1:0] size;
  logic [dmacc_pkg::ADDR_W-1:0] align;
  logic [dmacc_pkg::ADDR_W-1:0] dst_moved;
  logic [dmacc_pkg::ADDR_W-1:0] src_moved;
  logic [dmacc_pkg::CNT_W-1:0]  rem_dec;
  logic                         finished;

  assign dstep    = st.ctl[dmacc_pkg::CTL_DSTEP_LO +: 2];
  assign sstep    = st.ctl[dmacc_pkg::CTL_SSTEP_LO +: 2];
  assign wide     = st.ctl[dmacc_pkg::CTL_WIDE];
  assign size     = wide ? 28'd4 : 28'd2;
  assign align    = wide ? ~28'd3 : ~28'd1;
  assign rem_dec  = st.rem - 17'd1;
  assign finished = (rem_dec == 17'd0);

  always_comb begin
    case (dstep) inside
      dmacc_pkg::STEP_INC, dmacc_pkg::STEP_RELOAD: dst_moved = st.cur_dst + size;
      dmacc_pkg::STEP_DEC:                         dst_moved = st.cur_dst - size;
      default:                                     dst_moved = st.cur_dst;
    endcase
    case (sstep)
      dmacc_pkg::STEP_INC: src_moved = st.cur_src + size;
      dmacc_pkg::STEP_DEC: src_moved = st.cur_src - size;
      default:             src_moved = st.cur_src;
    endcase
  end

  always_comb begin
    upd.cur_src = src_moved;
    upd.cur_dst = dst_moved;
    upd.rem     = rem_dec;
    upd.ctl     = st.ctl;
    if (finished) begin
      if (dstep == dmacc_pkg::STEP_RELOAD) begin
        upd.cur_dst = dmacc_pkg::load_dst(ch, st.dst_reg);
      end
      if (st.ctl[dmacc_pkg::CTL_REPEAT]) begin
        upd.rem = dmacc_pkg::load_count(ch, st.cnt_reg);
      end else begin
        upd.ctl[dmacc_pkg::CTL_ENABLE] = 1'b0;
      end
    end
  end

  assign beat.channel    = ch;
  assign beat.read_addr  = st.cur_src & align;
  assign beat.write_addr = st.cur_dst & align;
  assign beat.wide       = wide;
  assign beat.finished   = finished;
  assign beat.irq        = finished & st.ctl[dmacc_pkg::CTL_IRQ];

endmodule

/* sv/dma_channel_controller_top.sv */
// Top level of the four-channel DMA address and count engine.
// Each input transfer passes through an input register and then the result register.
// Throughput: one item per cycle while m_tready does not stall the output; the served-channel
// state updates in the same cycle that the result register loads.
// Reset clears all channel registers, busy flags and both pipeline valid flags.
module dma_channel_controller_top #(
  parameter int CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // channel[1:0], register_select[3:2], write_data[35:4], zero pad
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // transfer_channel[1:0], read_address[29:2],
                                // write_address[57:30], word_is_32bit[58], irq_request[59], pad
  output logic        m_tlast,  // channel_finished
  output logic        m_tuser   // transfer_valid
);

  localparam int NCH = dmacc_pkg::MAX_CH;

  logic        in_valid;
  logic        in_mode;
  logic [1:0]  in_ch;
  logic [1:0]  in_sel;
  logic [31:0] in_data;
  logic        advance;

  logic [31:0]                  src_reg [NCH];
  logic [31:0]                  dst_reg [NCH];
  logic [15:0]                  cnt_reg [NCH];
  logic [15:0]                  ctl_reg [NCH];
  logic [dmacc_pkg::ADDR_W-1:0] cur_src [NCH];
  logic [dmacc_pkg::ADDR_W-1:0] cur_dst [NCH];
  logic [dmacc_pkg::CNT_W-1:0]  rem     [NCH];
  logic [NCH-1:0]               busy;

  logic [1:0]           served;
  logic                 any_busy;
  dmacc_pkg::chan_t     sel_st;
  dmacc_pkg::beat_t     beat;
  dmacc_pkg::chan_upd_t upd;
  logic                 do_step;

  logic                         out_xfer;
  logic [1:0]                   out_ch;
  logic [dmacc_pkg::ADDR_W-1:0] out_raddr;
  logic [dmacc_pkg::ADDR_W-1:0] out_waddr;
  logic                         out_wide;
  logic                         out_fin;
  logic                         out_irq;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_ch   <= s_tdata[1:0];
      in_sel  <= s_tdata[3:2];
      in_data <= s_tdata[35:4];
    end
  end

  always_comb begin
    served   = 2'd0;
    any_busy = 1'b0;
    for (int i = NCH - 1; i >= 0; i--) begin
      if (busy[i]) begin
        served   = 2'(i);
        any_busy = 1'b1;
      end
    end
  end

  assign sel_st.ctl     = ctl_reg[served];
  assign sel_st.dst_reg = dst_reg[served];
  assign sel_st.cnt_reg = cnt_reg[served];
  assign sel_st.cur_src = cur_src[served];
  assign sel_st.cur_dst = cur_dst[served];
  assign sel_st.rem     = rem[served];

  dmacc_step u_step (
    .st   (sel_st),
    .ch   (served),
    .beat (beat),
    .upd  (upd)
  );

  assign do_step = advance && (in_mode == dmacc_pkg::MODE_STEP) && any_busy;

  for (genvar c = 0; c < NCH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_on
      logic wr;
      logic stp;
      logic rising;

      assign wr     = advance && (in_mode == dmacc_pkg::MODE_WRITE) && (in_ch == 2'(c));
      assign stp    = do_step && (served == 2'(c));
      assign rising = in_data[dmacc_pkg::CTL_ENABLE] && !ctl_reg[c][dmacc_pkg::CTL_ENABLE];

      always_ff @(posedge clk) begin
        if (rst) begin
          src_reg[c] <= '0;
          dst_reg[c] <= '0;
          cnt_reg[c] <= '0;
          ctl_reg[c] <= '0;
          cur_src[c] <= '0;
          cur_dst[c] <= '0;
          rem[c]     <= '0;
          busy[c]    <= 1'b0;
        end else if (wr) begin
          unique case (in_sel)
            dmacc_pkg::REG_SRC: src_reg[c] <= in_data;
            dmacc_pkg::REG_DST: dst_reg[c] <= in_data;
            dmacc_pkg::REG_CNT: cnt_reg[c] <= in_data[15:0];
            dmacc_pkg::REG_CTL: begin
              ctl_reg[c] <= in_data[15:0];
              if (rising) begin
                cur_src[c] <= dmacc_pkg::load_src(2'(c), src_reg[c]);
                cur_dst[c] <= dmacc_pkg::load_dst(2'(c), dst_reg[c]);
                rem[c]     <= dmacc_pkg::load_count(2'(c), cnt_reg[c]);
                if (in_data[dmacc_pkg::CTL_TIMING_LO +: 2] == dmacc_pkg::TIMING_IMMEDIATE) begin
                  busy[c] <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end else if (stp) begin
          ctl_reg[c] <= upd.ctl;
          cur_src[c] <= upd.cur_src;
          cur_dst[c] <= upd.cur_dst;
          rem[c]     <= upd.rem;
          busy[c]    <= !beat.finished;
        end
      end
    end else begin : g_off
      assign src_reg[c] = '0;
      assign dst_reg[c] = '0;
      assign cnt_reg[c] = '0;
      assign ctl_reg[c] = '0;
      assign cur_src[c] = '0;
      assign cur_dst[c] = '0;
      assign rem[c]     = '0;
      assign busy[c]    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_xfer  <= do_step;
      out_ch    <= do_step ? beat.channel    : 2'd0;
      out_raddr <= do_step ? beat.read_addr  : '0;
      out_waddr <= do_step ? beat.write_addr : '0;
      out_wide  <= do_step && beat.wide;
      out_fin   <= do_step && beat.finished;
      out_irq   <= do_step && beat.irq;
    end
  end

  assign m_tuser = out_xfer;
  assign m_tlast = out_fin;
  assign m_tdata = {4'd0, out_irq, out_wide, out_waddr, out_raddr, out_ch};

endmodule
